// ===== hdl/evad_pkg.sv =====
package evad_pkg;

  // Detector states as they appear on the vad_state port.
  typedef enum logic [1:0] {
    VAD_SILENCE = 2'd0,
    VAD_SPEECH  = 2'd1,
    VAD_HANG    = 2'd2
  } vad_state_t;

  // Event codes as they appear on the event_code port.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2
  } event_code_t;

  // Sequencer of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_ROOT,
    S_NF_MUL,
    S_NF_ADD,
    S_NF_CLAMP,
    S_THR_MUL,
    S_THR_CLAMP,
    S_CMP,
    S_DECIDE
  } ctrl_state_t;

  // Phases of the shared shift-subtract unit.
  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT
  } ds_phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_THR  = 3'd0,
    REG_ADAPT_EN   = 3'd1,
    REG_HYST_RATIO = 3'd2,
    REG_DEBOUNCE   = 3'd3,
    REG_MIN_TALK   = 3'd4,
    REG_END_SIL    = 3'd5,
    REG_HANGOVER   = 3'd6,
    REG_PAUSE_TOL  = 3'd7
  } cfg_reg_t;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int ROOT_W   = 16;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int CNT_W    = 25;
  localparam int LIMIT_W  = 24;
  localparam int CFG_W    = 24;
  localparam int NF_W     = 32;
  localparam int PROD_W   = 49;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [15:0] ALPHA_Q16 = 16'd655;
  localparam logic [15:0] KEEP_Q16  = 16'd64881;

  localparam logic [15:0]     RST_START_THR  = 16'd655;
  localparam logic [8:0]      RST_HYST_RATIO = 9'd179;
  localparam logic [3:0]      RST_DEBOUNCE   = 4'd2;
  localparam logic [23:0]     RST_MIN_TALK   = 24'd4800;
  localparam logic [23:0]     RST_END_SIL    = 24'd12800;
  localparam logic [23:0]     RST_HANGOVER   = 24'd3200;
  localparam logic [23:0]     RST_PAUSE_TOL  = 24'd8000;
  localparam logic [NF_W-1:0] RST_NOISE      = 32'd655 << 16;

endpackage

// ===== hdl/evad_divsqrt.sv =====
module evad_divsqrt
  import evad_pkg::*;
#(
  parameter int SUM_W = 43,
  parameter int N_W   = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [N_W-1:0]    divisor,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int R_W    = (N_W + 2 > RAD_W / 2 + 3) ? N_W + 2 : RAD_W / 2 + 3;
  localparam int STEP_W = $clog2(SUM_W + 1);

  ds_phase_t          phase;
  logic [STEP_W-1:0]  cnt;
  logic [SUM_W-1:0]   work;
  logic [N_W-1:0]     dvs;
  logic [R_W-1:0]     rem;
  logic [RAD_W-1:0]   rad;
  logic [R_W-1:0]     rem_sh;
  logic [R_W-1:0]     trial;
  logic [R_W-1:0]     diff;
  logic               ge;

  // Operand select for the one shared compare-and-subtract.
  always_comb begin
    rem_sh = '0;
    trial  = '0;
    unique case (phase)
      DS_DIV: begin
        rem_sh = {rem[R_W-2:0], work[SUM_W-1]};
        trial  = R_W'(dvs);
      end
      DS_SQRT: begin
        rem_sh = {rem[R_W-3:0], rad[RAD_W-1:RAD_W-2]};
        trial  = R_W'({root, 2'b01});
      end
      default: begin
        rem_sh = '0;
        trial  = '0;
      end
    endcase
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  // Control of the phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DS_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        DS_IDLE: begin
          if (start) begin
            phase <= DS_DIV;
            cnt   <= '0;
          end
        end
        DS_DIV: begin
          if (cnt == STEP_W'(SUM_W - 1)) begin
            phase <= DS_SQRT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        DS_SQRT: begin
          if (cnt == STEP_W'(ROOT_W - 1)) begin
            phase <= DS_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: phase <= DS_IDLE;
      endcase
    end
  end

  // Datapath: one quotient bit or one root bit per cycle.
  always_ff @(posedge clk) begin
    case (phase)
      DS_IDLE: begin
        if (start) begin
          work <= dividend;
          dvs  <= divisor;
          rem  <= '0;
        end
      end
      DS_DIV: begin
        work <= {work[SUM_W-2:0], ge};
        if (cnt == STEP_W'(SUM_W - 1)) begin
          rad  <= RAD_W'({work[SUM_W-2:0], ge});
          rem  <= '0;
          root <= '0;
        end else begin
          rem <= ge ? diff : rem_sh;
        end
      end
      DS_SQRT: begin
        rem  <= ge ? diff : rem_sh;
        root <= {root[ROOT_W-2:0], ge};
        rad  <= {rad[RAD_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/energy_voice_activity_detector.sv =====
// Energy based voice activity detector.
// Input channel (in_valid / in_ready): one signed 16-bit sample per
// transaction; frame_last marks the last sample of a frame. A frame also
// closes by itself when it reaches MAX_FRAME samples.
// Output channel (out_valid / out_ready): one transaction per frame with the
// event, the detector state, the frame RMS, the start threshold used and the
// noise floor, the last three in Q0.15 of full scale.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// in the cycle it is high; write only while the block is idle.
// Sequence: a sample that does not close a frame is accepted, then
// accumulated. A closing sample also runs the shared shift-subtract
// unit, one quotient bit per cycle for the mean and one root bit per cycle
// for the RMS, then seven sequencer steps for noise floor, threshold and
// decision; the noise floor add and clamp steps are skipped when the noise
// floor is left unchanged.
// The result sits in an output register; the next frame's samples are taken
// while it waits. Only a later frame end stalls, in its decision step, until
// the receiver takes the previous result.
// Reset clears the sums, counters and detector state, reloads the register
// defaults and sets the noise floor to its start value.
module energy_voice_activity_detector
  import evad_pkg::*;
#(
  parameter int MAX_FRAME     = 4096,
  parameter int ADAPT_MULT_Q4 = 48,
  parameter int ADAPT_MIN     = 328,
  parameter int ADAPT_MAX     = 3277
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   sample,
  input  logic                 frame_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_code,
  output logic [1:0]           vad_state,
  output logic                 speech_active,
  output logic [15:0]          frame_rms,
  output logic [15:0]          effective_threshold,
  output logic [15:0]          noise_level,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int N_W   = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = 30 + N_W;
  localparam logic [63:0] NF_LO = (64'(ADAPT_MIN) << 20) / ADAPT_MULT_Q4;
  localparam logic [63:0] NF_HI = (64'(ADAPT_MAX) << 20) / ADAPT_MULT_Q4;
  localparam logic [LEVEL_W-1:0] A_MIN = LEVEL_W'(ADAPT_MIN);
  localparam logic [LEVEL_W-1:0] A_MAX = LEVEL_W'(ADAPT_MAX);

  // Configuration registers.
  logic [15:0]        start_threshold;
  logic               adaptive_enable;
  logic [8:0]         hyst_ratio;
  logic [3:0]         loud_frames_req;
  logic [LIMIT_W-1:0] min_talk_samples;
  logic [LIMIT_W-1:0] end_silence_samples;
  logic [LIMIT_W-1:0] hangover_samples;
  logic [LIMIT_W-1:0] pause_tolerance_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold         <= RST_START_THR;
      adaptive_enable         <= 1'b0;
      hyst_ratio              <= RST_HYST_RATIO;
      loud_frames_req         <= RST_DEBOUNCE;
      min_talk_samples        <= RST_MIN_TALK;
      end_silence_samples     <= RST_END_SIL;
      hangover_samples        <= RST_HANGOVER;
      pause_tolerance_samples <= RST_PAUSE_TOL;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_THR:  start_threshold         <= cfg_data[15:0];
        REG_ADAPT_EN:   adaptive_enable         <= cfg_data[0];
        REG_HYST_RATIO: hyst_ratio              <= cfg_data[8:0];
        REG_DEBOUNCE:   loud_frames_req         <= cfg_data[3:0];
        REG_MIN_TALK:   min_talk_samples        <= cfg_data[LIMIT_W-1:0];
        REG_END_SIL:    end_silence_samples     <= cfg_data[LIMIT_W-1:0];
        REG_HANGOVER:   hangover_samples        <= cfg_data[LIMIT_W-1:0];
        REG_PAUSE_TOL:  pause_tolerance_samples <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctrl_state_t         state, state_next;
  logic [SAMPLE_W-1:0] raw;
  logic                last;
  logic [SUM_W-1:0]    square_sum;
  logic [N_W-1:0]      frame_count;
  logic [N_W-1:0]      n;
  logic [LEVEL_W-1:0]  rms;
  logic [NF_W-1:0]     floor_est;
  logic [PROD_W-1:0]   prod;
  logic [LEVEL_W-1:0]  thr;
  logic                over_start;
  logic                over_end;
  vad_state_t          dstate;
  logic [3:0]          loud_frame_run;
  logic [CNT_W-1:0]    speech_count, quiet_count, hang_count;

  logic [15:0]         mag;
  logic [31:0]         sq;
  logic [SUM_W-1:0]    sum_next;
  logic [N_W-1:0]      count_next;
  logic                frame_end;
  logic                ds_start, ds_done;
  logic [ROOT_W-1:0]   ds_root;
  logic                can_out;

  // Sample energy and frame end detection.
  always_comb begin
    mag        = raw[15] ? (~raw + 16'd1) : raw;
    sq         = 32'(mag) * 32'(mag);
    sum_next   = square_sum + SUM_W'(sq);
    count_next = frame_count + 1'b1;
    frame_end  = last || (32'(count_next) >= 32'(MAX_FRAME));
  end

  assign in_ready = (state == S_IDLE);
  assign ds_start = (state == S_ACC) && frame_end;
  assign can_out  = !out_valid || out_ready;

  evad_divsqrt #(
    .SUM_W (SUM_W),
    .N_W   (N_W)
  ) u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ds_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (ds_done),
    .root     (ds_root)
  );

  // Noise floor and threshold arithmetic.
  logic             nf_cond;
  logic [32:0]      nf_raw;
  logic [63:0]      nf_clamp;
  logic [15:0]      top;
  logic [28:0]      a_raw;
  logic [15:0]      thr_calc;
  logic [24:0]      thr_hyst;

  always_comb begin
    nf_cond  = adaptive_enable && (dstate == VAD_SILENCE) &&
               ({1'b0, rms, 16'b0} < {floor_est, 1'b0});
    nf_raw   = prod[48:16];
    nf_clamp = 64'(nf_raw);
    if (nf_clamp > NF_HI) nf_clamp = NF_HI;
    if (nf_clamp < NF_LO) nf_clamp = NF_LO;
    top      = (start_threshold > A_MAX) ? start_threshold : A_MAX;
    a_raw    = prod[48:20];
    if (a_raw > 29'(top)) thr_calc = top;
    else thr_calc = a_raw[15:0];
    if (29'(thr_calc) < 29'(A_MIN)) thr_calc = A_MIN;
    thr_hyst = 25'(thr) * 25'(hyst_ratio);
  end

  // Detector decision at frame end.
  vad_state_t       ds_n;
  event_code_t      ev;
  logic [3:0]       run_n;
  logic [CNT_W-1:0] sp_n, qt_n, hg_n;
  logic [CNT_W-1:0] n_c;
  logic [CNT_W:0]   sp_add, qt_add, hg_add;
  logic [CNT_W-1:0] sp_sat, qt_sat, hg_sat;
  logic [3:0]       run_inc;

  always_comb begin
    n_c    = CNT_W'(n);
    sp_add = {1'b0, speech_count} + {1'b0, n_c};
    qt_add = {1'b0, quiet_count} + {1'b0, n_c};
    hg_add = {1'b0, hang_count} + {1'b0, n_c};
    sp_sat = (sp_add > {1'b0, CNT_MAX}) ? CNT_MAX : sp_add[CNT_W-1:0];
    qt_sat = (qt_add > {1'b0, CNT_MAX}) ? CNT_MAX : qt_add[CNT_W-1:0];
    hg_sat = (hg_add > {1'b0, CNT_MAX}) ? CNT_MAX : hg_add[CNT_W-1:0];
    run_inc = (loud_frame_run < 4'd15) ? loud_frame_run + 4'd1 : loud_frame_run;
    ds_n  = dstate;
    ev    = EV_NONE;
    run_n = loud_frame_run;
    sp_n  = speech_count;
    qt_n  = quiet_count;
    hg_n  = hang_count;
    unique case (dstate)
      VAD_SILENCE: begin
        if (over_start) begin
          run_n = run_inc;
          if (run_inc >= loud_frames_req) begin
            ds_n  = VAD_SPEECH;
            sp_n  = n_c;
            qt_n  = '0;
            run_n = '0;
            ev    = EV_START;
          end
        end else begin
          run_n = '0;
        end
      end
      VAD_SPEECH: begin
        if (over_end) begin
          sp_n = sp_sat;
          qt_n = '0;
        end else begin
          qt_n = qt_sat;
          if (qt_sat >= CNT_W'(pause_tolerance_samples) &&
              qt_sat >= CNT_W'(end_silence_samples)) begin
            if (speech_count >= CNT_W'(min_talk_samples)) begin
              ds_n = VAD_HANG;
              hg_n = '0;
              ev   = EV_END;
            end else begin
              ds_n = VAD_SILENCE;
              sp_n = '0;
              qt_n = '0;
            end
          end
        end
      end
      VAD_HANG: begin
        hg_n = hg_sat;
        if (over_end) begin
          ds_n = VAD_SPEECH;
          sp_n = sp_sat;
          qt_n = '0;
          hg_n = '0;
        end else if (hg_sat >= CNT_W'(hangover_samples)) begin
          ds_n = VAD_SILENCE;
          sp_n = '0;
          qt_n = '0;
          hg_n = '0;
        end
      end
      default: ds_n = VAD_SILENCE;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_ACC;
      S_ACC:       state_next = frame_end ? S_ROOT : S_IDLE;
      S_ROOT:      if (ds_done) state_next = S_NF_MUL;
      S_NF_MUL:    state_next = nf_cond ? S_NF_ADD : S_THR_MUL;
      S_NF_ADD:    state_next = S_NF_CLAMP;
      S_NF_CLAMP:  state_next = S_THR_MUL;
      S_THR_MUL:   state_next = S_THR_CLAMP;
      S_THR_CLAMP: state_next = S_CMP;
      S_CMP:       state_next = S_DECIDE;
      S_DECIDE:    if (can_out) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Control state: sums, counters, detector and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      frame_count    <= '0;
      floor_est      <= RST_NOISE;
      dstate         <= VAD_SILENCE;
      loud_frame_run <= '0;
      speech_count   <= '0;
      quiet_count    <= '0;
      hang_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_ACC) begin
        square_sum  <= frame_end ? '0 : sum_next;
        frame_count <= frame_end ? '0 : count_next;
      end
      if (state == S_NF_CLAMP) floor_est <= nf_clamp[NF_W-1:0];
      if (state == S_DECIDE && can_out) begin
        dstate         <= ds_n;
        loud_frame_run <= run_n;
        speech_count   <= sp_n;
        quiet_count    <= qt_n;
        hang_count     <= hg_n;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw  <= sample;
      last <= frame_last;
    end
    if (ds_start) n <= count_next;
    if (ds_done) rms <= ds_root;
    case (state)
      S_NF_MUL:    prod <= PROD_W'(floor_est) * PROD_W'(KEEP_Q16);
      S_NF_ADD:    prod <= prod + PROD_W'({26'(rms) * 26'(ALPHA_Q16), 16'b0});
      S_THR_MUL:   prod <= PROD_W'(floor_est) * PROD_W'(ADAPT_MULT_Q4);
      S_THR_CLAMP: thr  <= adaptive_enable ? thr_calc : start_threshold;
      S_CMP: begin
        over_start <= rms > thr;
        over_end   <= 25'({rms, 8'b0}) > thr_hyst;
      end
      S_DECIDE: begin
        if (can_out) begin
          event_code          <= ev;
          vad_state           <= ds_n;
          speech_active       <= (ds_n != VAD_SILENCE);
          frame_rms           <= rms;
          effective_threshold <= thr;
          noise_level         <= floor_est[NF_W-1:16];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/evad_checker.sv =====
module evad_checker
  import evad_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_code,
  input logic [1:0]  vad_state,
  input logic        speech_active,
  input logic [15:0] frame_rms
);

  // A result waiting for the receiver stays offered, with its frame RMS unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_rms))
    else $error("output transaction dropped or changed while stalled");

  // Activity flag agrees with the reported state.
  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speech_active == (vad_state != VAD_SILENCE))
    else $error("speech_active disagrees with vad_state");

  // A start event always leaves the detector in speech.
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == EV_START |-> vad_state == VAD_SPEECH)
    else $error("speech start without speech state");

  // An end event always leaves the detector in hangover.
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code == EV_END |-> vad_state == VAD_HANG)
    else $error("speech end without hangover state");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .event_code    (event_code),
  .vad_state     (vad_state),
  .speech_active (speech_active),
  .frame_rms     (frame_rms)
);

// ===== tb/tb_energy_voice_activity_detector.sv =====
module tb_energy_voice_activity_detector
  import evad_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_MAX = 4096;
  localparam int MULT_Q4 = 48;
  localparam int FLOOR_MIN = 328;
  localparam int FLOOR_MAX = 3277;
  localparam int STALL_LIMIT = 20000;
  localparam logic [24:0] COUNT_TOP = {25{1'b1}};

  typedef struct packed {
    logic [1:0] ev;
    logic [1:0] st;
    logic act;
    logic [15:0] rms;
    logic [15:0] thr;
    logic [15:0] noise;
  } frame_report_t;

  // Tracks detector state and the queue of frame reports still due.
  class vad_scoreboard;
    logic [15:0] start_thr;
    logic adapt_en;
    logic [8:0] hyst;
    logic [3:0] debounce;
    logic [23:0] min_talk, end_sil, hangover, pause_tol;
    logic [42:0] energy_sum;
    int unsigned frame_len;
    vad_state_t det_state;
    logic [3:0] loud_run;
    logic [24:0] speech_cnt, quiet_cnt, hang_cnt;
    logic [31:0] floor_q16;
    frame_report_t pending_reports[$];
    int errors;
    int frames_seen;
    int starts_seen;
    int ends_seen;

    function new();
      start_thr = RST_START_THR;
      adapt_en = 1'b0;
      hyst = RST_HYST_RATIO;
      debounce = RST_DEBOUNCE;
      min_talk = RST_MIN_TALK;
      end_sil = RST_END_SIL;
      hangover = RST_HANGOVER;
      pause_tol = RST_PAUSE_TOL;
      energy_sum = '0;
      frame_len = 0;
      det_state = VAD_SILENCE;
      loud_run = '0;
      speech_cnt = '0;
      quiet_cnt = '0;
      hang_cnt = '0;
      floor_q16 = RST_NOISE;
      errors = 0;
      frames_seen = 0;
      starts_seen = 0;
      ends_seen = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [23:0] val);
      case (idx)
        REG_START_THR: start_thr = val[15:0];
        REG_ADAPT_EN: adapt_en = val[0];
        REG_HYST_RATIO: hyst = val[8:0];
        REG_DEBOUNCE: debounce = val[3:0];
        REG_MIN_TALK: min_talk = val;
        REG_END_SIL: end_sil = val;
        REG_HANGOVER: hangover = val;
        REG_PAUSE_TOL: pause_tol = val;
        default: ;
      endcase
    endfunction

    function logic [24:0] count_add(logic [24:0] a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > COUNT_TOP) ? COUNT_TOP : s[24:0];
    endfunction

    function logic [31:0] int_root(logic [63:0] x);
      logic [63:0] r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
        if (x >= r + bit_v) begin
          x -= r + bit_v;
          r = (r >> 1) + bit_v;
        end else begin
          r >>= 1;
        end
        bit_v >>= 2;
      end
      return r[31:0];
    endfunction

    // Accumulates one sample and predicts the frame report when it closes a frame.
    function void note_sample(logic signed [15:0] smp, logic last);
      longint unsigned mag, r16, nf, lo, hi, a, top;
      int unsigned n;
      logic [31:0] rms, thr;
      logic over_start, over_end;
      event_code_t ev;
      frame_report_t rep;
      mag = (smp < 0) ? -longint'(smp) : longint'(smp);
      energy_sum += mag * mag;
      frame_len++;
      if (!last && frame_len < FRAME_MAX) return;
      n = frame_len;
      rms = int_root(64'(energy_sum) / n);
      energy_sum = '0;
      frame_len = 0;
      ev = EV_NONE;
      if (adapt_en && det_state == VAD_SILENCE) begin
        r16 = longint'(rms) << 16;
        nf = floor_q16;
        lo = (longint'(FLOOR_MIN) << 20) / MULT_Q4;
        hi = (longint'(FLOOR_MAX) << 20) / MULT_Q4;
        if (r16 < 2 * nf) begin
          nf = (nf * (65536 - 655) + r16 * 655) >> 16;
          if (nf > hi) nf = hi;
          if (nf < lo) nf = lo;
          floor_q16 = nf[31:0];
        end
      end
      if (!adapt_en) thr = start_thr;
      else begin
        a = (longint'(floor_q16) * MULT_Q4) >> 20;
        top = (start_thr > FLOOR_MAX) ? start_thr : FLOOR_MAX;
        if (a > top) a = top;
        if (a < FLOOR_MIN) a = FLOOR_MIN;
        thr = a[31:0];
      end
      over_start = rms > thr;
      over_end = longint'(rms) * 256 > longint'(thr) * hyst;
      case (det_state)
        VAD_SILENCE: begin
          if (over_start) begin
            if (loud_run < 15) loud_run++;
            if (loud_run >= debounce) begin
              det_state = VAD_SPEECH;
              speech_cnt = (n > COUNT_TOP) ? COUNT_TOP : 25'(n);
              quiet_cnt = '0;
              loud_run = '0;
              ev = EV_START;
            end
          end else begin
            loud_run = '0;
          end
        end
        VAD_SPEECH: begin
          if (over_end) begin
            speech_cnt = count_add(speech_cnt, n);
            quiet_cnt = '0;
          end else begin
            quiet_cnt = count_add(quiet_cnt, n);
            if (quiet_cnt >= pause_tol && quiet_cnt >= end_sil) begin
              if (speech_cnt >= min_talk) begin
                det_state = VAD_HANG;
                hang_cnt = '0;
                ev = EV_END;
              end else begin
                det_state = VAD_SILENCE;
                speech_cnt = '0;
                quiet_cnt = '0;
              end
            end
          end
        end
        default: begin
          hang_cnt = count_add(hang_cnt, n);
          if (over_end) begin
            det_state = VAD_SPEECH;
            speech_cnt = count_add(speech_cnt, n);
            quiet_cnt = '0;
            hang_cnt = '0;
          end else if (hang_cnt >= hangover) begin
            det_state = VAD_SILENCE;
            speech_cnt = '0;
            quiet_cnt = '0;
            hang_cnt = '0;
          end
        end
      endcase
      rep.ev = ev;
      rep.st = det_state;
      rep.act = (det_state != VAD_SILENCE);
      rep.rms = rms[15:0];
      rep.thr = thr[15:0];
      rep.noise = floor_q16[31:16];
      pending_reports.push_back(rep);
    endfunction

    // Compares one output transaction with the oldest predicted report.
    function void check_report(frame_report_t got);
      frame_report_t exp_rep;
      frames_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report %p", $realtime, got);
        errors++;
        return;
      end
      exp_rep = pending_reports.pop_front();
      if (got.ev == EV_START) starts_seen++;
      if (got.ev == EV_END) ends_seen++;
      if (got.ev !== exp_rep.ev)
        $display("%0t: event_code expected %0d actual %0d", $realtime, exp_rep.ev, got.ev);
      if (got.st !== exp_rep.st)
        $display("%0t: vad_state expected %0d actual %0d", $realtime, exp_rep.st, got.st);
      if (got.act !== exp_rep.act)
        $display("%0t: speech_active expected %0d actual %0d", $realtime, exp_rep.act,
                 got.act);
      if (got.rms !== exp_rep.rms)
        $display("%0t: frame_rms expected %0d actual %0d", $realtime, exp_rep.rms, got.rms);
      if (got.thr !== exp_rep.thr)
        $display("%0t: effective_threshold expected %0d actual %0d", $realtime, exp_rep.thr,
                 got.thr);
      if (got.noise !== exp_rep.noise)
        $display("%0t: noise_level expected %0d actual %0d", $realtime, exp_rep.noise,
                 got.noise);
      if (got !== exp_rep) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample = '0;
  logic frame_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] event_code;
  logic [1:0] vad_state;
  logic speech_active;
  logic [15:0] frame_rms;
  logic [15:0] effective_threshold;
  logic [15:0] noise_level;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  vad_scoreboard board = new();
  int idle_cycles = 0;
  int samples_sent = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  logic [15:0] sample_or = '0;
  logic [15:0] sample_and = '1;

  energy_voice_activity_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .frame_last(frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_code(event_code), .vad_state(vad_state), .speech_active(speech_active),
    .frame_rms(frame_rms), .effective_threshold(effective_threshold),
    .noise_level(noise_level),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls per transaction, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      board.check_report({event_code, vad_state, speech_active, frame_rms,
                          effective_threshold, noise_level});
    end
  end

  task automatic write_config(cfg_reg_t idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Waits for every predicted report and lets the final frame's pipeline drain.
  task automatic wait_quiet();
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] smp, logic last, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    sample <= smp;
    frame_last <= last;
    @(posedge clk iff in_ready);
    in_valid <= 1'b0;
    board.note_sample(smp, last);
    sample_or |= smp;
    sample_and &= smp;
    samples_sent++;
    @(posedge clk);
  endtask

  // One frame with samples of random sign up to a chosen amplitude.
  task automatic send_frame(int len, int amp, bit gaps);
    int k;
    int v;
    for (k = 0; k < len; k++) begin
      v = $urandom_range(0, amp);
      if ($urandom_range(0, 1)) v = -v;
      send_sample(16'(v), k == len - 1, gaps);
    end
  endtask

  task automatic pick_config(bit extreme);
    write_config(REG_START_THR, extreme ? 24'($urandom_range(0, 1) ? 0 : 32768)
                                        : 24'($urandom_range(200, 6000)));
    write_config(REG_ADAPT_EN, 24'($urandom_range(0, 1)));
    write_config(REG_HYST_RATIO, extreme ? 24'($urandom_range(0, 1) ? 0 : 256)
                                         : 24'($urandom_range(64, 256)));
    write_config(REG_DEBOUNCE, extreme ? 24'($urandom_range(0, 1) ? 1 : 15)
                                       : 24'($urandom_range(0, 4)));
    write_config(REG_MIN_TALK, 24'($urandom_range(0, 40)));
    write_config(REG_END_SIL, 24'($urandom_range(0, 40)));
    write_config(REG_HANGOVER, 24'($urandom_range(0, 40)));
    write_config(REG_PAUSE_TOL, extreme ? 24'hFFFFFF : 24'($urandom_range(0, 40)));
  endtask

  initial begin
    int phase;
    int amp;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sample extremes, single-sample frames and a zero debounce.
    write_config(REG_DEBOUNCE, 24'd0);
    write_config(REG_MIN_TALK, 24'd2);
    write_config(REG_END_SIL, 24'd3);
    write_config(REG_PAUSE_TOL, 24'd5);
    write_config(REG_HANGOVER, 24'd2);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b1);
    send_sample(16'sh7FFF, 1'b1, 1'b1);
    repeat (6) send_sample(16'sd0, 1'b1, 1'b1);
    send_sample(16'sh5555, 1'b1, 1'b0);
    send_sample(16'shAAAA, 1'b1, 1'b0);
    repeat (4) send_sample(16'sd1, 1'b1, 1'b0);
    wait_quiet();

    // Quiet frames in adaptive mode so the noise floor moves while silent.
    write_config(REG_ADAPT_EN, 24'd1);
    write_config(REG_DEBOUNCE, 24'd15);
    repeat (6) send_frame(4, 200, 1'b0);
    wait_quiet();

    // Random phases with small frames, each under a new register setting.
    for (phase = 0; phase < 12; phase++) begin
      pick_config(phase % 3 == 0);
      repeat (20) begin
        amp = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 4000);
        send_frame($urandom_range(1, 8), amp, $urandom_range(0, 2) != 0);
      end
      // The sender pauses here until every report has come back.
      wait_quiet();
    end

    // Long receiver hold-off while the sender keeps offering frames.
    long_hold = 1'b1;
    repeat (40) send_frame($urandom_range(1, 3), 32767, 1'b0);
    wait_quiet();

    if (sample_or !== 16'hFFFF || sample_and !== 16'h0000)
      $display("note: not every sample bit toggled");
    $display("Sent %0d samples; %0d frame reports checked, %0d starts, %0d ends.",
             samples_sent, board.frames_seen, board.starts_seen, board.ends_seen);
    if (board.errors == 0 && board.pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
